[rtl/csc_pkg.sv]
//------------------------------------------------------------------------------
// csc_pkg
// Shared types, register codes and CRC helpers for the configuration stream
// CRC checker.
//------------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int CSC_WORD_W     = 32;
  localparam int CSC_ADDR_W     = 5;
  localparam int CSC_ABITS_W    = 3;
  localparam int CSC_CFG_DATA_W = 5;
  localparam int CSC_CFG_IDX_W  = 3;
  localparam int CSC_FOLD_BITS  = CSC_WORD_W + (1 << CSC_ABITS_W) - 1;

  localparam logic [31:0] CSC_CRC32_POLY = 32'h1edc6f41;
  localparam logic [15:0] CSC_CRC16_POLY = 16'h8005;

  typedef enum logic [CSC_CFG_IDX_W-1:0] {
    REG_CRC_KIND     = 3'd0,
    REG_ADDRESS_BITS = 3'd1,
    REG_CRC_ADDR     = 3'd2,
    REG_CMD_ADDR     = 3'd3,
    REG_RESET_CMD    = 3'd4,
    REG_FDRI_ADDR    = 3'd5,
    REG_AUTO_CRC     = 3'd6
  } csc_reg_e;

  typedef enum logic {
    SRC_CRC_WRITE = 1'b0,
    SRC_AUTO_CRC  = 1'b1
  } csc_source_e;

  typedef struct packed {
    logic [CSC_WORD_W-1:0] word_value;
    logic [CSC_ADDR_W-1:0] reg_address;
    logic                  first_of_packet;
    logic                  last_of_packet;
  } csc_item_t;

  typedef struct packed {
    logic [CSC_WORD_W-1:0] crc_value;
    logic                  crc_source;
  } csc_result_t;

  // word bits lsb first, then the low address bits lsb first
  function automatic logic [31:0] csc_fold(
    input logic [31:0]            rem,
    input logic                   kind16,
    input logic [CSC_WORD_W-1:0]  word,
    input logic [CSC_ADDR_W-1:0]  addr,
    input logic [CSC_ABITS_W-1:0] nbits
  );
    logic [31:0] r;
    logic        b;
    logic        top;
    r = rem;
    for (int i = 0; i < CSC_FOLD_BITS; i++) begin
      if (i < CSC_WORD_W) begin
        b = word[i];
      end else if (i < CSC_WORD_W + CSC_ADDR_W) begin
        b = addr[i-CSC_WORD_W];
      end else begin
        b = 1'b0;
      end
      if ((i < CSC_WORD_W) || ((i - CSC_WORD_W) < int'(nbits))) begin
        if (kind16) begin
          top = r[15] ^ b;
          r   = {16'b0, r[14:0], 1'b0} ^ (top ? {16'b0, CSC_CRC16_POLY} : 32'b0);
        end else begin
          top = r[31] ^ b;
          r   = {r[30:0], 1'b0} ^ (top ? CSC_CRC32_POLY : 32'b0);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] csc_reflect(
    input logic [31:0] rem,
    input logic        kind16
  );
    logic [31:0] v32;
    logic [15:0] v16;
    for (int i = 0; i < 32; i++) begin
      v32[i] = rem[31-i];
    end
    for (int i = 0; i < 16; i++) begin
      v16[i] = rem[15-i];
    end
    return kind16 ? {16'b0, v16} : v32;
  endfunction

endpackage

`default_nettype wire

[rtl/csc_stream_if.sv]
//------------------------------------------------------------------------------
// csc_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
//------------------------------------------------------------------------------
`default_nettype none

interface csc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/config_stream_crc_checker.sv]
//------------------------------------------------------------------------------
// config_stream_crc_checker
// Running CRC over configuration write payload words with register address.
//------------------------------------------------------------------------------
// Takes one payload word per cycle on words and delivers a reflected CRC on
// crcs after a CRC register write, or after a frame data packet when auto CRC
// is on. A word is captured in an input register and folded from there: the
// 32 data bits plus up to seven address bits (zeros past bit four) go through
// one unrolled CRC update against the remainder register, so a new word is
// taken every cycle. A result passes the input and output registers before
// it is offered on crcs. A result held in the output register stalls the
// input only when the next word also produces a result. Registers are written
// on cfg_wr_en, by the user only while idle; the block does not enforce it.
//------------------------------------------------------------------------------
`default_nettype none

module config_stream_crc_checker
  import csc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CSC_CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CSC_CFG_DATA_W-1:0] cfg_data,
  csc_stream_if.sink                     words,
  csc_stream_if.source                   crcs
);

  logic                   crc_kind;
  logic [CSC_ABITS_W-1:0] address_bits;
  logic [CSC_ADDR_W-1:0]  crc_reg_addr;
  logic [CSC_ADDR_W-1:0]  cmd_reg_addr;
  logic [CSC_ADDR_W-1:0]  reset_crc_command;
  logic [CSC_ADDR_W-1:0]  fdri_reg_addr;
  logic                   auto_crc_enable;

  logic        s1_valid;
  csc_item_t   s1_item;
  logic [31:0] crc_remainder;
  logic        skip_packet;
  logic        out_valid;
  csc_result_t out_data;

  logic [31:0] crc_remainder_next;
  logic        skip_packet_next;
  logic [31:0] folded;
  logic        do_fold;
  logic        emit;
  csc_result_t emit_data;
  logic        advance;

  always_comb begin
    folded             = csc_fold(crc_remainder, crc_kind, s1_item.word_value,
                                  s1_item.reg_address, address_bits);
    crc_remainder_next = crc_remainder;
    skip_packet_next   = skip_packet;
    do_fold            = 1'b0;
    emit               = 1'b0;
    emit_data          = '{crc_value: csc_reflect(crc_remainder, crc_kind),
                           crc_source: SRC_CRC_WRITE};
    if (s1_item.first_of_packet && (s1_item.reg_address == crc_reg_addr)) begin
      emit               = 1'b1;
      crc_remainder_next = '0;
      skip_packet_next   = !s1_item.last_of_packet;
    end else if (s1_item.first_of_packet && (s1_item.reg_address == cmd_reg_addr) &&
                 (s1_item.word_value ==
                  {{(CSC_WORD_W-CSC_ADDR_W){1'b0}}, reset_crc_command})) begin
      crc_remainder_next = '0;
      skip_packet_next   = !s1_item.last_of_packet;
    end else if (!s1_item.first_of_packet && skip_packet) begin
      if (s1_item.last_of_packet) begin
        skip_packet_next = 1'b0;
      end
    end else begin
      do_fold            = 1'b1;
      crc_remainder_next = folded;
      skip_packet_next   = 1'b0;
      if (s1_item.last_of_packet && auto_crc_enable &&
          (s1_item.reg_address == fdri_reg_addr) &&
          (s1_item.reg_address != crc_reg_addr)) begin
        emit               = 1'b1;
        emit_data          = '{crc_value: csc_reflect(folded, crc_kind),
                               crc_source: SRC_AUTO_CRC};
        crc_remainder_next = '0;
      end
    end
  end

  assign advance     = s1_valid && (!emit || !out_valid || crcs.ready);
  assign words.ready = !s1_valid || advance;
  assign crcs.valid  = out_valid;
  assign crcs.data   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_kind          <= 1'b0;
      address_bits      <= 3'd5;
      crc_reg_addr      <= 5'd0;
      cmd_reg_addr      <= 5'd4;
      reset_crc_command <= 5'd7;
      fdri_reg_addr     <= 5'd2;
      auto_crc_enable   <= 1'b0;
      s1_valid          <= 1'b0;
      crc_remainder     <= '0;
      skip_packet       <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (csc_reg_e'(cfg_index))
          REG_CRC_KIND:     crc_kind          <= cfg_data[0];
          REG_ADDRESS_BITS: address_bits      <= cfg_data[CSC_ABITS_W-1:0];
          REG_CRC_ADDR:     crc_reg_addr      <= cfg_data[CSC_ADDR_W-1:0];
          REG_CMD_ADDR:     cmd_reg_addr      <= cfg_data[CSC_ADDR_W-1:0];
          REG_RESET_CMD:    reset_crc_command <= cfg_data[CSC_ADDR_W-1:0];
          REG_FDRI_ADDR:    fdri_reg_addr     <= cfg_data[CSC_ADDR_W-1:0];
          REG_AUTO_CRC:     auto_crc_enable   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (words.ready) begin
        s1_valid <= words.valid;
        s1_item  <= words.data;
      end
      if (advance) begin
        crc_remainder <= crc_remainder_next;
        skip_packet   <= skip_packet_next;
      end
      if (crcs.ready) begin
        out_valid <= 1'b0;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
        out_data  <= emit_data;
      end
    end
  end

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |-> (!out_valid || crcs.ready))
    else $error("result register overwritten while held");

  a_clear_after_crc_write: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.first_of_packet && (s1_item.reg_address == crc_reg_addr))
    |=> (crc_remainder == '0))
    else $error("remainder not cleared by crc register write");

  a_crc16_upper_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && do_fold && crc_kind) |=> (crc_remainder[31:16] == '0))
    else $error("crc-16 fold left upper remainder bits");

  a_crc16_result_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && crc_kind) |-> (out_data.crc_value[31:16] == '0))
    else $error("crc-16 result has upper bits set");

endmodule

`default_nettype wire
